FILE: sv/tosa_pkg.sv
// shared constants for the triangle overlap separating axis core
// no dependencies

package tosa_pkg;

   localparam int NUM_TRIS        = 2;
   localparam int NUM_VERTS       = 3;
   localparam int NUM_EDGES       = 3;
   localparam int NUM_COORDS      = 2 * NUM_VERTS;
   localparam int NUM_AXES        = NUM_TRIS * NUM_EDGES;
   localparam int NUM_FIELDS      = NUM_TRIS * NUM_COORDS;
   localparam int RSP_TDATA_WIDTH = 8;

endpackage

FILE: sv/tosa_project.sv
// edge normal axes and vertex products, registered
// depends on tosa_pkg

module tosa_project #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic load,
   input  logic signed [COORD_WIDTH-1:0]
                coord [tosa_pkg::NUM_TRIS][tosa_pkg::NUM_COORDS],
   output logic signed [2*COORD_WIDTH:0]
                prod_x [tosa_pkg::NUM_AXES][tosa_pkg::NUM_TRIS][tosa_pkg::NUM_VERTS],
   output logic signed [2*COORD_WIDTH:0]
                prod_y [tosa_pkg::NUM_AXES][tosa_pkg::NUM_TRIS][tosa_pkg::NUM_VERTS]
);
   import tosa_pkg::*;

   localparam int NW = COORD_WIDTH + 1;
   localparam int PW = 2 * COORD_WIDTH + 1;

   logic signed [PW-1:0] prod_x_in [NUM_AXES][NUM_TRIS][NUM_VERTS];
   logic signed [PW-1:0] prod_y_in [NUM_AXES][NUM_TRIS][NUM_VERTS];
   logic signed [PW-1:0] prod_x_ff [NUM_AXES][NUM_TRIS][NUM_VERTS];
   logic signed [PW-1:0] prod_y_ff [NUM_AXES][NUM_TRIS][NUM_VERTS];

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      localparam int T = a / NUM_EDGES;
      localparam int E = a % NUM_EDGES;
      localparam int N = (E + 1) % NUM_EDGES;

      logic signed [NW-1:0] dx;
      logic signed [NW-1:0] dy;
      logic signed [NW-1:0] nx;
      logic signed [NW-1:0] ny;

      assign dx = NW'(coord[T][2*N])   - NW'(coord[T][2*E]);
      assign dy = NW'(coord[T][2*N+1]) - NW'(coord[T][2*E+1]);
      // axis is the edge rotated by 90 degrees
      assign nx = -dy;
      assign ny = dx;

      for (genvar t = 0; t < NUM_TRIS; t++) begin : g_tri
         for (genvar k = 0; k < NUM_VERTS; k++) begin : g_vert
            assign prod_x_in[a][t][k] = PW'(nx) * PW'(coord[t][2*k]);
            assign prod_y_in[a][t][k] = PW'(ny) * PW'(coord[t][2*k+1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
   end

   assign prod_x = prod_x_ff;
   assign prod_y = prod_y_ff;

endmodule

FILE: sv/tosa_interval.sv
// projections and min/max interval per axis and triangle, registered
// depends on tosa_pkg

module tosa_interval #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic load,
   input  logic signed [2*COORD_WIDTH:0]
                prod_x [tosa_pkg::NUM_AXES][tosa_pkg::NUM_TRIS][tosa_pkg::NUM_VERTS],
   input  logic signed [2*COORD_WIDTH:0]
                prod_y [tosa_pkg::NUM_AXES][tosa_pkg::NUM_TRIS][tosa_pkg::NUM_VERTS],
   output logic signed [2*COORD_WIDTH+1:0] lo [tosa_pkg::NUM_AXES][tosa_pkg::NUM_TRIS],
   output logic signed [2*COORD_WIDTH+1:0] hi [tosa_pkg::NUM_AXES][tosa_pkg::NUM_TRIS]
);
   import tosa_pkg::*;

   localparam int SW = 2 * COORD_WIDTH + 2;

   logic signed [SW-1:0] lo_in [NUM_AXES][NUM_TRIS];
   logic signed [SW-1:0] hi_in [NUM_AXES][NUM_TRIS];
   logic signed [SW-1:0] lo_ff [NUM_AXES][NUM_TRIS];
   logic signed [SW-1:0] hi_ff [NUM_AXES][NUM_TRIS];

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      for (genvar t = 0; t < NUM_TRIS; t++) begin : g_tri
         logic signed [SW-1:0] proj [NUM_VERTS];
         logic signed [SW-1:0] lo01;
         logic signed [SW-1:0] hi01;

         for (genvar k = 0; k < NUM_VERTS; k++) begin : g_vert
            assign proj[k] = SW'(prod_x[a][t][k]) + SW'(prod_y[a][t][k]);
         end

         assign lo01 = (proj[1] < proj[0]) ? proj[1] : proj[0];
         assign hi01 = (proj[0] < proj[1]) ? proj[1] : proj[0];
         assign lo_in[a][t] = (proj[2] < lo01) ? proj[2] : lo01;
         assign hi_in[a][t] = (hi01 < proj[2]) ? proj[2] : hi01;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;

endmodule

FILE: sv/tosa_compare.sv
// interval overlap test on every axis and final overlap flag, registered
// depends on tosa_pkg

module tosa_compare #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic load,
   input  logic signed [2*COORD_WIDTH+1:0] lo [tosa_pkg::NUM_AXES][tosa_pkg::NUM_TRIS],
   input  logic signed [2*COORD_WIDTH+1:0] hi [tosa_pkg::NUM_AXES][tosa_pkg::NUM_TRIS],
   output logic overlap
);
   import tosa_pkg::*;

   logic [NUM_AXES-1:0] apart;
   logic                overlap_in;
   logic                overlap_ff;

   // touching intervals count as separated
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      assign apart[a] = !((lo[a][0] < hi[a][1]) && (lo[a][1] < hi[a][0]));
   end

   assign overlap_in = ~|apart;

   always_ff @(posedge clock) begin
      if (load) begin
         overlap_ff <= overlap_in;
      end
   end

   assign overlap = overlap_ff;

endmodule

FILE: sv/triangle_overlap_separating_axis_core.sv
// top level of the 2d triangle overlap core, separating axis test
// depends on tosa_pkg, tosa_project, tosa_interval, tosa_compare
//
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     req_tdata: 12 coordinates, first triangle first
// rsp      out  rsp_tvalid/tready     rsp_tdata: overlap flag in bit 0
//
// one transaction per cycle sustained while rsp is not stalled; rsp_tvalid rises
// once a transaction has passed the input, product, interval and result registers
// the multiplier stage (one product per vertex coordinate and axis) sets the clock
// synchronous active high reset clears all stage valid flags
// a stalled rsp holds the pipeline; empty stages still fill, so req stays ready
// until all four stages hold a transaction

module triangle_overlap_separating_axis_core #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_v0_x, first_v0_y, first_v1_x, first_v1_y, first_v2_x, first_v2_y,
   // second_v0_x, second_v0_y, second_v1_x, second_v1_y, second_v2_x, second_v2_y
   input  logic [((tosa_pkg::NUM_FIELDS*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // overlap, then zero fill
   output logic [tosa_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import tosa_pkg::*;

   localparam int PW = 2 * COORD_WIDTH + 1;
   localparam int SW = 2 * COORD_WIDTH + 2;

   logic signed [COORD_WIDTH-1:0] coord_in [NUM_TRIS][NUM_COORDS];
   logic signed [COORD_WIDTH-1:0] coord_ff [NUM_TRIS][NUM_COORDS];
   logic signed [PW-1:0]          prod_x [NUM_AXES][NUM_TRIS][NUM_VERTS];
   logic signed [PW-1:0]          prod_y [NUM_AXES][NUM_TRIS][NUM_VERTS];
   logic signed [SW-1:0]          lo [NUM_AXES][NUM_TRIS];
   logic signed [SW-1:0]          hi [NUM_AXES][NUM_TRIS];
   logic                          overlap;

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic v0_in, v1_in, v2_in, v3_in;
   logic ld0, ld1, ld2, ld3;

   assign ld3 = !v3_ff || rsp_tready;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign ld0 = !v0_ff || ld1;

   assign v0_in = ld0 ? req_tvalid : v0_ff;
   assign v1_in = ld1 ? v0_ff : v1_ff;
   assign v2_in = ld2 ? v1_ff : v2_ff;
   assign v3_in = ld3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   for (genvar t = 0; t < NUM_TRIS; t++) begin : g_tri
      for (genvar c = 0; c < NUM_COORDS; c++) begin : g_coord
         assign coord_in[t][c] = req_tdata[(t*NUM_COORDS+c)*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (ld0) begin
         coord_ff <= coord_in;
      end
   end

   tosa_project #(.COORD_WIDTH(COORD_WIDTH)) u_project (
      .clock  (clock),
      .load   (ld1),
      .coord  (coord_ff),
      .prod_x (prod_x),
      .prod_y (prod_y)
   );

   tosa_interval #(.COORD_WIDTH(COORD_WIDTH)) u_interval (
      .clock  (clock),
      .load   (ld2),
      .prod_x (prod_x),
      .prod_y (prod_y),
      .lo     (lo),
      .hi     (hi)
   );

   tosa_compare #(.COORD_WIDTH(COORD_WIDTH)) u_compare (
      .clock   (clock),
      .load    (ld3),
      .lo      (lo),
      .hi      (hi),
      .overlap (overlap)
   );

   assign req_tready = ld0;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {{(RSP_TDATA_WIDTH-1){1'b0}}, overlap};

endmodule
